FILE: src/mic_e_pkg.sv
package mic_e_pkg;

    localparam int unsigned FRAME_DEST = 6;
    localparam int unsigned FRAME_LEN  = 20;

    localparam logic [2:0] REG_MESSAGE_TYPE      = 3'd0;
    localparam logic [2:0] REG_ALT_SYMBOL_SELECT = 3'd1;
    localparam logic [2:0] REG_SYMBOL_TABLE_MAIN = 3'd2;
    localparam logic [2:0] REG_SYMBOL_CODE_MAIN  = 3'd3;
    localparam logic [2:0] REG_SYMBOL_TABLE_ALT  = 3'd4;
    localparam logic [2:0] REG_SYMBOL_CODE_ALT   = 3'd5;

    localparam logic [7:0] CHR_MARKER  = 8'h60;
    localparam logic [7:0] CHR_CLOSE   = 8'h7D;
    localparam logic [7:0] CHR_BLANK_S = 8'h5A;
    localparam logic [7:0] CHR_BLANK_C = 8'h4C;
    localparam logic [7:0] CHR_DIGIT_S = 8'h50;
    localparam logic [7:0] CHR_DIGIT_C = 8'h30;

    localparam logic [7:0] OFS_BASE91  = 8'd33;
    localparam logic [7:0] OFS_FIELD   = 8'd28;

    localparam logic signed [20:0] ALT_MIN  = -21'sd10000;
    localparam logic signed [20:0] ALT_MAX  = 21'sd743570;
    localparam logic signed [20:0] ALT_BIAS = 21'sd10000;

    localparam logic [19:0] RECIP_8281 = 20'd1037307;
    localparam logic [20:0] RECIP_91   = 21'd1474921;
    localparam logic [7:0]  RECIP_10   = 8'd205;
    localparam logic [5:0]  RECIP_100  = 6'd41;

    typedef struct packed {
        logic [23:0] lat;
        logic        north;
        logic        west;
        logic [7:0]  deg;
        logic [5:0]  mins;
        logic [6:0]  hund;
        logic [9:0]  speed;
        logic [6:0]  speed_q;
        logic [8:0]  head;
        logic [1:0]  head_q;
        logic [19:0] biased;
        logic [6:0]  alt_q2;
        logic [13:0] alt_q1;
    } fix_t;

    function automatic logic [7:0] dest_char(input logic [3:0] digit, input logic flag);
        logic [7:0] base;
        base = flag ? CHR_DIGIT_S : CHR_DIGIT_C;
        if (digit > 4'd9) begin
            dest_char = flag ? CHR_BLANK_S : CHR_BLANK_C;
        end else begin
            dest_char = base + {4'd0, digit};
        end
    endfunction

endpackage

FILE: src/mic_e_position_encoder_top.sv
// Mic-E position encoder.
// s_ channel: one position fix per transaction, packed into s_tdata.
// m_ channel: the encoded frame, one byte per transaction, twenty bytes per
//   fix: six destination address bytes (m_tuser = 0) then fourteen info
//   field bytes (m_tuser = 1); m_tlast marks the twentieth byte.
// cfg_ channel: register writes, always ready; indexes 6 and 7 are ignored.
//   Write only while no frame is pending.
// The fix is registered in the input register, then its frame is loaded into
//   the frame register, which drives the bytes. Throughput: one byte per cycle
//   while m_tready is high, stepped by the byte counter. A fix held in the
//   input register waits while the previous frame drains, and s_tready drops
//   only when both the input register and the frame register are occupied.
// Stall: while m_tready is low the current byte and the counter hold.
// Reset (aresetn low at a clock edge): both stages empty, counter at zero,
//   registers back to message type 0, main symbol, table 47, code 62.
module mic_e_position_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // lat_digits[23:0], north[24], lon_degrees[32:25], lon_minutes[38:33],
    // lon_hundredths[45:39], west[46], speed_knots[56:47], heading[65:57],
    // altitude[86:66], zero pad[87]
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_byte[7:0]
    output logic [7:0]  m_tdata,
    // in_info_field[0]
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import mic_e_pkg::*;

    logic [2:0] message_type_reg;
    logic       alt_symbol_select_reg;
    logic [7:0] symbol_table_main_reg;
    logic [7:0] symbol_code_main_reg;
    logic [7:0] symbol_table_alt_reg;
    logic [7:0] symbol_code_alt_reg;

    fix_t       s1_reg;
    fix_t       s1_next;
    logic       s1_valid_reg;

    logic [7:0] frame_reg [FRAME_LEN];
    logic [7:0] frame_next [FRAME_LEN];
    logic       frame_valid_reg;
    logic [4:0] count_reg;

    logic       frame_load;
    logic       out_done;
    logic       s_accept;

    logic signed [20:0] alt_in;
    logic signed [20:0] alt_sat;
    logic [20:0]        biased_w;
    logic [39:0]        p8281;
    logic [40:0]        p91;
    logic [17:0]        p10;
    logic [14:0]        p100;

    logic [2:0]  msg;
    logic [5:0]  flags;
    logic        offset;
    logic [7:0]  degcode;
    logic [7:0]  mcode;
    logic [13:0] d1_w;
    logic [19:0] d2_w;
    logic [8:0]  hrem;
    logic [13:0] b11_w;
    logic [7:0]  symbol_code;
    logic [7:0]  symbol_table;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            message_type_reg      <= 3'd0;
            alt_symbol_select_reg <= 1'b0;
            symbol_table_main_reg <= 8'd47;
            symbol_code_main_reg  <= 8'd62;
            symbol_table_alt_reg  <= 8'd47;
            symbol_code_alt_reg   <= 8'd62;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MESSAGE_TYPE:      message_type_reg      <= cfg_data[2:0];
                REG_ALT_SYMBOL_SELECT: alt_symbol_select_reg <= cfg_data[0];
                REG_SYMBOL_TABLE_MAIN: symbol_table_main_reg <= cfg_data;
                REG_SYMBOL_CODE_MAIN:  symbol_code_main_reg  <= cfg_data;
                REG_SYMBOL_TABLE_ALT:  symbol_table_alt_reg  <= cfg_data;
                REG_SYMBOL_CODE_ALT:   symbol_code_alt_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturate the fix and start the divisions by reciprocal multiply
    always_comb begin
        s1_next.lat   = s_tdata[23:0];
        s1_next.north = s_tdata[24];
        s1_next.deg   = (s_tdata[32:25] > 8'd179) ? 8'd179 : s_tdata[32:25];
        s1_next.mins  = (s_tdata[38:33] > 6'd59) ? 6'd59 : s_tdata[38:33];
        s1_next.hund  = (s_tdata[45:39] > 7'd99) ? 7'd99 : s_tdata[45:39];
        s1_next.west  = s_tdata[46];
        s1_next.speed = (s_tdata[56:47] > 10'd799) ? 10'd799 : s_tdata[56:47];
        s1_next.head  = (s_tdata[65:57] > 9'd360) ? 9'd360 : s_tdata[65:57];

        alt_in = $signed(s_tdata[86:66]);
        if (alt_in < ALT_MIN) begin
            alt_sat = ALT_MIN;
        end else if (alt_in > ALT_MAX) begin
            alt_sat = ALT_MAX;
        end else begin
            alt_sat = alt_in;
        end
        biased_w       = 21'(alt_sat + ALT_BIAS);
        s1_next.biased = biased_w[19:0];

        p8281 = 40'(s1_next.biased) * 40'(RECIP_8281);
        p91   = 41'(s1_next.biased) * 41'(RECIP_91);
        p10   = 18'(s1_next.speed) * 18'(RECIP_10);
        p100  = 15'(s1_next.head) * 15'(RECIP_100);

        s1_next.alt_q2  = p8281[39:33];
        s1_next.alt_q1  = p91[40:27];
        s1_next.speed_q = p10[17:11];
        s1_next.head_q  = p100[13:12];
    end

    // assemble all twenty bytes of the frame
    always_comb begin
        msg = (message_type_reg < 3'd7) ? (3'd7 - message_type_reg) : 3'd0;

        if (s1_reg.deg < 8'd10) begin
            degcode = 8'd118 + s1_reg.deg;
            offset  = 1'b1;
        end else if (s1_reg.deg < 8'd100) begin
            degcode = s1_reg.deg + OFS_FIELD;
            offset  = 1'b0;
        end else if (s1_reg.deg < 8'd110) begin
            degcode = s1_reg.deg + 8'd8;
            offset  = 1'b1;
        end else begin
            degcode = s1_reg.deg - 8'd72;
            offset  = 1'b1;
        end

        flags = {s1_reg.west, offset, s1_reg.north, msg[0], msg[1], msg[2]};

        mcode = {2'd0, s1_reg.mins} + OFS_FIELD;
        if (mcode < 8'd38) begin
            mcode = mcode + 8'd60;
        end

        d1_w  = s1_reg.alt_q1 - 14'(s1_reg.alt_q2) * 14'd91;
        d2_w  = s1_reg.biased - 20'(s1_reg.alt_q1) * 20'd91;
        hrem  = s1_reg.head - 9'(s1_reg.head_q) * 9'd100;
        b11_w = 14'(s1_reg.speed) * 14'd10 - 14'(s1_reg.speed_q) * 14'd100
                + 14'(s1_reg.head_q) + 14'(OFS_FIELD);

        symbol_code  = alt_symbol_select_reg ? symbol_code_alt_reg : symbol_code_main_reg;
        symbol_table = alt_symbol_select_reg ? symbol_table_alt_reg : symbol_table_main_reg;

        for (int k = 0; k < FRAME_DEST; k++) begin
            frame_next[k] = dest_char(s1_reg.lat[20 - 4 * k +: 4], flags[k]);
        end
        frame_next[6]  = CHR_MARKER;
        frame_next[7]  = degcode;
        frame_next[8]  = mcode;
        frame_next[9]  = {1'b0, s1_reg.hund} + OFS_FIELD;
        frame_next[10] = {1'b0, s1_reg.speed_q} + OFS_FIELD;
        frame_next[11] = b11_w[7:0];
        frame_next[12] = hrem[7:0] + OFS_FIELD;
        frame_next[13] = symbol_code;
        frame_next[14] = symbol_table;
        frame_next[15] = CHR_MARKER;
        frame_next[16] = {1'b0, s1_reg.alt_q2} + OFS_BASE91;
        frame_next[17] = {1'b0, d1_w[6:0]} + OFS_BASE91;
        frame_next[18] = {1'b0, d2_w[6:0]} + OFS_BASE91;
        frame_next[19] = CHR_CLOSE;
    end

    assign out_done   = frame_valid_reg && m_tready && (count_reg == 5'(FRAME_LEN - 1));
    assign frame_load = s1_valid_reg && (!frame_valid_reg || out_done);
    assign s_tready   = !s1_valid_reg || frame_load;
    assign s_accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_reg <= s1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_load) begin
            frame_reg <= frame_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_valid_reg <= 1'b0;
            count_reg       <= 5'd0;
        end else if (frame_load) begin
            frame_valid_reg <= 1'b1;
            count_reg       <= 5'd0;
        end else if (out_done) begin
            frame_valid_reg <= 1'b0;
            count_reg       <= 5'd0;
        end else if (frame_valid_reg && m_tready) begin
            count_reg <= count_reg + 5'd1;
        end
    end

    assign m_tvalid = frame_valid_reg;
    assign m_tdata  = frame_reg[count_reg];
    assign m_tuser  = (count_reg >= 5'(FRAME_DEST));
    assign m_tlast  = (count_reg == 5'(FRAME_LEN - 1));

    a_last_in_info: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("frame end outside info field");

    a_drain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        out_done && !s1_valid_reg |=> !m_tvalid)
        else $error("frame register not released after last byte");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && count_reg == $past(count_reg) + 5'd1)
        else $error("byte counter skipped");

    a_refill: assert property (@(posedge aclk) disable iff (!aresetn)
        out_done && s1_valid_reg |=> m_tvalid && count_reg == 5'd0)
        else $error("queued fix not loaded after frame end");

endmodule
